// ===== rtl/core/nsck_pkg.sv =====
package nsck_pkg;

	// source store geometry
	localparam int unsigned MAX_SRC_PIXELS = 65536;
	localparam int unsigned ADDR_W         = $clog2(MAX_SRC_PIXELS);
	localparam int unsigned PIX_W          = 32;

	// picture sizes and coordinates
	localparam int unsigned MAX_DIM = 1024;
	localparam int unsigned COORD_W = $clog2(MAX_DIM);
	localparam int unsigned SIZE_W  = COORD_W + 1;

	// coordinate times size, also the widest scaled quotient
	localparam int unsigned PROD_W = COORD_W + SIZE_W;
	// scaled row times source width
	localparam int unsigned ROW_W  = PROD_W + SIZE_W;
	// linear source address with one carry bit
	localparam int unsigned LIN_W  = ROW_W + 1;

	// divide step counter
	localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

	localparam int unsigned KEY_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// register reset values
	localparam logic [SIZE_W-1:0] SIZE_RESET      = SIZE_W'(64);
	localparam logic [KEY_W-1:0]  KEY_GREEN_RESET = KEY_W'(162);
	localparam logic [KEY_W-1:0]  KEY_BLUE_RESET  = KEY_W'(232);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_KEY_GREEN  = 3'd4,
		REG_KEY_BLUE   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_FETCH = 1'b1
	} kind_t;

	typedef enum logic {
		STATUS_OK  = 1'b0,
		STATUS_OOB = 1'b1
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  load_addr;
		logic [PIX_W-1:0]   load_pixel;
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_pixel;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		status_t            status;
	} result_t;

	// divider handshake
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/nsck_ram.sv =====
module nsck_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/nsck_div.sv =====
module nsck_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [nsck_pkg::PROD_W-1:0]      dividend,
	input  logic [nsck_pkg::SIZE_W-1:0]      divisor,
	output nsck_pkg::div_stat_t              stat,
	output logic [nsck_pkg::PROD_W-1:0]      quotient
);

	logic                               busy_q;
	logic                               done_q;
	logic [nsck_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               zero_q;
	logic [nsck_pkg::SIZE_W-1:0]        dvs_q;
	logic [nsck_pkg::SIZE_W-1:0]        rem_q;
	logic [nsck_pkg::PROD_W-1:0]        quo_q;
	logic [nsck_pkg::SIZE_W:0]          trial;
	logic                               fits;

	// one restoring step per cycle, msb first
	assign trial = {rem_q, quo_q[nsck_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == nsck_pkg::DIV_CNT_W'(nsck_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + nsck_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= nsck_pkg::SIZE_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[nsck_pkg::SIZE_W-1:0];
			end
			quo_q <= {quo_q[nsck_pkg::PROD_W-2:0], fits};
		end
	end

	// a zero size maps every coordinate to zero
	assign quotient  = zero_q ? '0 : quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/core/nearest_scale_color_key.sv =====
// Nearest-neighbor scaler with color-key transparency. Load beats write one
// 32-bit BGRA pixel into a 64K-word source store; while no fetch is in
// progress a load may follow a load in every cycle. Fetch beats name a
// destination pixel (x, y), which maps to source column x*src_width/dst_width
// and row y*src_height/dst_height, both exact floor quotients. The two
// quotients come from a pair of bit-serial dividers running side by side, one
// quotient bit a cycle over 21 bits, and that divider loop sets the cost: a
// fetch occupies the block from acceptance until its result is registered
// (start, 21 divide steps, the done state that registers the row multiply,
// scale, address add and store read, key stage). The pixel at linear address
// column + row*src_width is read; when red is zero, green is at least the
// green key and blue is at least the blue key, alpha is cleared. A linear
// address beyond the store returns status 1 with a zero pixel. Store words
// that were never loaded read back as whatever the RAM holds. A finished
// result waits in an output register, so the next beat is taken while it
// waits; a fetch finishing behind a stalled result holds until it drains.
// Configuration writes are always taken and must only be made while idle.
module nearest_scale_color_key (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  nsck_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output nsck_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nsck_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nsck_pkg::SIZE_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_SCALE,
		ST_ADDR,
		ST_READ
	} state_t;

	state_t state_q;

	// configuration registers
	logic [nsck_pkg::SIZE_W-1:0] src_width_q;
	logic [nsck_pkg::SIZE_W-1:0] src_height_q;
	logic [nsck_pkg::SIZE_W-1:0] dst_width_q;
	logic [nsck_pkg::SIZE_W-1:0] dst_height_q;
	logic [nsck_pkg::KEY_W-1:0]  key_green_q;
	logic [nsck_pkg::KEY_W-1:0]  key_blue_q;

	// fetch context
	logic [nsck_pkg::COORD_W-1:0] x_q;
	logic [nsck_pkg::COORD_W-1:0] y_q;
	logic [nsck_pkg::PROD_W-1:0]  prod_x_q;
	logic [nsck_pkg::PROD_W-1:0]  prod_y_q;
	logic [nsck_pkg::PROD_W-1:0]  sx_q;
	logic [nsck_pkg::ROW_W-1:0]   row_off_q;
	logic                         oob_q;

	// output register
	logic              result_valid_q;
	nsck_pkg::result_t result_q;

	logic                         accept;
	logic                         load_beat;
	logic                         fetch_beat;
	logic                         div_start;
	nsck_pkg::div_stat_t          stat_x;
	nsck_pkg::div_stat_t          stat_y;
	logic [nsck_pkg::PROD_W-1:0]  quo_x;
	logic [nsck_pkg::PROD_W-1:0]  quo_y;
	logic [nsck_pkg::LIN_W-1:0]   lin_addr;
	logic                         in_store;
	logic                         ram_re;
	logic [nsck_pkg::PIX_W-1:0]   ram_rdata;
	logic                         keyed;
	logic [nsck_pkg::PIX_W-1:0]   pix_out;
	logic                         out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign load_beat  = accept && (item.kind == nsck_pkg::KIND_LOAD);
	assign fetch_beat = accept && (item.kind == nsck_pkg::KIND_FETCH);
	assign cfg_ready  = 1'b1;
	assign out_free   = !result_valid_q || result_ready;

	// configuration writes, unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nsck_pkg::SIZE_RESET;
			src_height_q <= nsck_pkg::SIZE_RESET;
			dst_width_q  <= nsck_pkg::SIZE_RESET;
			dst_height_q <= nsck_pkg::SIZE_RESET;
			key_green_q  <= nsck_pkg::KEY_GREEN_RESET;
			key_blue_q   <= nsck_pkg::KEY_BLUE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				nsck_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				nsck_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				nsck_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				nsck_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				nsck_pkg::REG_KEY_GREEN:  key_green_q  <= cfg_data[nsck_pkg::KEY_W-1:0];
				nsck_pkg::REG_KEY_BLUE:   key_blue_q   <= cfg_data[nsck_pkg::KEY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// source store: loads write straight from the input beat, fetches read
	// once the linear address is known; the block is busy then, so a read
	// never meets a write
	nsck_ram #(
		.WIDTH (nsck_pkg::PIX_W),
		.DEPTH (nsck_pkg::MAX_SRC_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (load_beat),
		.waddr (item.load_addr),
		.wdata (item.load_pixel),
		.re    (ram_re),
		.raddr (lin_addr[nsck_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// column and row quotients run in lockstep
	assign div_start = (state_q == ST_START);

	nsck_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_x_q),
		.divisor  (dst_width_q),
		.stat     (stat_x),
		.quotient (quo_x)
	);

	nsck_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_y_q),
		.divisor  (dst_height_q),
		.stat     (stat_y),
		.quotient (quo_y)
	);

	// linear address: a column past the source width just runs on,
	// only the store bound is checked
	assign lin_addr = {1'b0, row_off_q} + nsck_pkg::LIN_W'(sx_q);
	assign in_store = lin_addr < nsck_pkg::LIN_W'(nsck_pkg::MAX_SRC_PIXELS);
	assign ram_re   = (state_q == ST_ADDR) && in_store;

	// color key: no red, enough green and blue
	assign keyed = (ram_rdata[23:16] == '0)
		&& (ram_rdata[15:8] >= key_green_q)
		&& (ram_rdata[7:0] >= key_blue_q);

	always_comb begin
		if (oob_q) begin
			pix_out = '0;
		end else if (keyed) begin
			pix_out = {8'h00, ram_rdata[23:0]};
		end else begin
			pix_out = ram_rdata;
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// a new result may replace a draining one in the same cycle
			if ((state_q == ST_READ) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fetch_beat) begin
						state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (stat_x.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_ADDR;
				ST_ADDR:  state_q <= ST_READ;
				ST_READ: begin
					// hold the read data until the output slot frees up
					if (out_free) begin
						result_q.out_pixel <= pix_out;
						result_q.out_x     <= x_q;
						result_q.out_y     <= y_q;
						result_q.status    <= oob_q ? nsck_pkg::STATUS_OOB
							: nsck_pkg::STATUS_OK;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fetch_beat) begin
			x_q      <= item.dst_x;
			y_q      <= item.dst_y;
			prod_x_q <= nsck_pkg::PROD_W'(item.dst_x) * nsck_pkg::PROD_W'(src_width_q);
			prod_y_q <= nsck_pkg::PROD_W'(item.dst_y) * nsck_pkg::PROD_W'(src_height_q);
		end
		if ((state_q == ST_DIV) && stat_x.done) begin
			sx_q      <= quo_x;
			row_off_q <= nsck_pkg::ROW_W'(quo_y) * nsck_pkg::ROW_W'(src_width_q);
		end
		if (state_q == ST_ADDR) begin
			oob_q <= !in_store;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// both dividers finish together
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat_x.done == stat_y.done)
		else $error("column and row dividers out of step");

	// no divide in flight while the block takes beats
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !stat_x.busy && !stat_y.busy)
		else $error("divider busy while idle");

	// a new result only comes out of the key stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_READ))
		else $error("result raised outside the key stage");

	// an out-of-store fetch carries a zero pixel
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.status == nsck_pkg::STATUS_OOB)
		|-> result_q.out_pixel == '0)
		else $error("out-of-store result with nonzero pixel");

endmodule
